>>> sv/velocity_command_smoother_top_defines.svh
// assertion macros for the velocity command smoother
// no dependencies; included by files that carry assertions
`ifndef VELOCITY_COMMAND_SMOOTHER_TOP_DEFINES_SVH
`define VELOCITY_COMMAND_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication
`define VCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/vcs_pkg.sv
// shared constants, types and rounding helper for the velocity command smoother
// no dependencies
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int AXIS_COUNT = 3;
  localparam int AX_FWD     = 0;
  localparam int AX_SIDE    = 1;
  localparam int AX_YAW     = 2;

  localparam int VEL_W      = 16;
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 15;
  localparam int ERR_W      = 17;
  localparam int RATE_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // rounding shifts of the three products
  localparam int unsigned RND_P = 24;
  localparam int unsigned RND_D = 8;
  localparam int unsigned RND_S = 16;

  // plus one in Q2.14, the clamp limit
  localparam logic signed [VEL_W-1:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH_ENABLE  = 4'd0,
    REG_PROP_GAIN      = 4'd1,
    REG_DIFF_GAIN      = 4'd2,
    REG_MOVE_THRESHOLD = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              smooth_en;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kw;
    logic [THR_W-1:0]  thr;
  } vcs_cfg_t;

  // mutually exclusive stage enables from the sequencer
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic step;
    logic fin;
  } vcs_ctrl_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel;
    logic                    moving;
  } vcs_lane_res_t;

  // arithmetic shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic signed [63:0] half;
    logic signed [63:0] adj;
    half = 64'sd1 <<< (sh - 1);
    adj  = v + half - {63'd0, v[63]};
    return adj >>> sh;
  endfunction

endpackage

>>> sv/vcs_channels.sv
// valid/ready channel interfaces: command request, result request, config write
// no dependencies
`timescale 1ns / 1ps

interface vcs_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_fwd;
  logic signed [15:0] cmd_side;
  logic signed [15:0] cmd_yaw;
  logic        [15:0] step_time;

  modport source(output valid, output cmd_fwd, output cmd_side, output cmd_yaw,
                 output step_time, input ready);
  modport sink(input valid, input cmd_fwd, input cmd_side, input cmd_yaw,
               input step_time, output ready);
endinterface

interface vcs_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_fwd;
  logic signed [15:0] out_side;
  logic signed [15:0] out_yaw;
  logic               is_moving;

  modport source(output valid, output out_fwd, output out_side, output out_yaw,
                 output is_moving, input ready);
  modport sink(input valid, input out_fwd, input out_side, input out_yaw,
               input is_moving, output ready);
endinterface

interface vcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/velocity_command_smoother_top.sv
// velocity command smoother top level: config registers, stage sequencer,
// one lane per axis and the merge stage; depends on vcs_pkg, vcs_channels,
// vcs_lane, vcs_merge and the assertion macro header
//
//  channel  dir  payload                                     handshake
//  cmd_ch   in   cmd_fwd cmd_side cmd_yaw step_time          valid/ready
//  res_ch   out  out_fwd out_side out_yaw is_moving          valid/ready
//  cfg_ch   in   index data (register write)                 valid/ready
//
// one item at a time, a new request is taken only in idle: the accept cycle,
// then four sequencer steps through the lane multiply chain (kp*err*dt,
// accumulate, rate*dt, output update); the last step loads the result register
// reset is synchronous, state zeroed at once; no clearing pass
// the last step waits while an earlier result is still not taken; a new
// request is taken while the result register is full
`timescale 1ns / 1ps
`include "velocity_command_smoother_top_defines.svh"

module velocity_command_smoother_top (
  input logic       clk,
  input logic       rst,
  vcs_cmd_if.sink   cmd_ch,
  vcs_res_if.source res_ch,
  vcs_cfg_if.sink   cfg_ch
);
  import vcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_STEP,
    S_FIN
  } state_t;

  state_t        state;
  vcs_cfg_t      cfg;
  vcs_ctrl_t     ctrl;
  logic          slot_free;
  vcs_lane_res_t lane_res [AXIS_COUNT];
  logic signed [VEL_W-1:0] lane_cmd [AXIS_COUNT];

  assign cfg_ch.ready = 1'b1;
  assign cmd_ch.ready = (state == S_IDLE);

  always_comb begin
    ctrl.load = cmd_ch.valid && cmd_ch.ready;
    ctrl.mul  = (state == S_MUL);
    ctrl.acc  = (state == S_ACC);
    ctrl.step = (state == S_STEP);
    ctrl.fin  = (state == S_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_en <= 1'b1;
      cfg.kp        <= 16'd256;
      cfg.kw        <= 16'd0;
      cfg.thr       <= 15'd164;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_SMOOTH_ENABLE:  cfg.smooth_en <= cfg_ch.data[0];
        REG_PROP_GAIN:      cfg.kp        <= cfg_ch.data;
        REG_DIFF_GAIN:      cfg.kw        <= cfg_ch.data;
        REG_MOVE_THRESHOLD: cfg.thr       <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (ctrl.load) state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC:  state <= S_STEP;
        S_STEP: state <= S_FIN;
        S_FIN:  if (ctrl.fin) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    lane_cmd[AX_FWD]  = cmd_ch.cmd_fwd;
    lane_cmd[AX_SIDE] = cmd_ch.cmd_side;
    lane_cmd[AX_YAW]  = cmd_ch.cmd_yaw;
  end

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
    vcs_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .cmd       (lane_cmd[g]),
      .step_time (cmd_ch.step_time),
      .res       (lane_res[g])
    );
  end

  vcs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_res  (lane_res),
    .fin       (ctrl.fin),
    .slot_free (slot_free),
    .res_ch    (res_ch)
  );

  `VCS_ASSERT_NEXT(a_load_starts, clk, rst, ctrl.load, state == S_MUL,
                   "request did not start the sequencer")
  `VCS_ASSERT_NEXT(a_fin_shows, clk, rst, ctrl.fin, res_ch.valid,
                   "finished item not shown as result")
  `VCS_ASSERT_NEXT(a_fin_holds, clk, rst,
                   (state == S_FIN) && res_ch.valid && !res_ch.ready, state == S_FIN,
                   "last step left while result register full")
  `VCS_ASSERT_NOW(a_no_overlap, clk, rst, state != S_IDLE, !cmd_ch.ready,
                  "request taken while an item is in flight")

endmodule

>>> sv/vcs_lane.sv
// one axis of the smoother: tracking law, dead band, moving test and clamp
// depends on vcs_pkg; stepped by the sequencer in the top level
`timescale 1ns / 1ps

module vcs_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  vcs_pkg::vcs_cfg_t     cfg,
  input  vcs_pkg::vcs_ctrl_t    ctrl,
  input  logic signed [15:0]    cmd,
  input  logic        [15:0]    step_time,
  output vcs_pkg::vcs_lane_res_t res
);
  import vcs_pkg::*;

  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  // axis state
  logic signed [VEL_W-1:0]  held;
  logic signed [RATE_W-1:0] rate;
  logic signed [ERR_W-1:0]  prev_err;

  // stage registers
  logic signed [VEL_W-1:0]  cmd_q;
  logic        [DT_W-1:0]   dt_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [33:0]       prod_p;
  logic signed [34:0]       prod_d;
  logic signed [50:0]       p_full;
  logic signed [26:0]       d_q;
  logic signed [RATE_W-1:0] r_q;
  logic signed [48:0]       m_q;

  logic signed [ERR_W-1:0]  err_new;
  logic signed [ERR_W:0]    diff_new;
  logic signed [DT_W:0]     dt_s;
  logic signed [63:0]       d_rnd;
  logic signed [63:0]       p_rnd;
  logic signed [63:0]       s_rnd;
  logic signed [26:0]       p_new;
  logic signed [33:0]       r_sum;
  logic signed [RATE_W-1:0] r_sat;
  logic signed [32:0]       step_new;
  logic signed [33:0]       o_wide;
  logic signed [33:0]       o_dz;
  logic signed [33:0]       thr_w;
  logic signed [33:0]       one_w;
  logic signed [VEL_W-1:0]  o_clamped;
  logic                     in_band;

  always_comb begin
    err_new  = {cmd[VEL_W-1], cmd} - {held[VEL_W-1], held};
    diff_new = {err_new[ERR_W-1], err_new} - {prev_err[ERR_W-1], prev_err};
    dt_s     = $signed({1'b0, dt_q});

    d_rnd = round_shift(64'(prod_d), RND_D);
    p_rnd = round_shift(64'(p_full), RND_P);
    p_new = p_rnd[26:0];

    r_sum = 34'(rate) + 34'(p_new) + 34'(d_q);
    if (r_sum > 34'(RATE_MAX)) begin
      r_sat = RATE_MAX;
    end else if (r_sum < 34'(RATE_MIN)) begin
      r_sat = RATE_MIN;
    end else begin
      r_sat = r_sum[RATE_W-1:0];
    end

    s_rnd    = round_shift(64'(m_q), RND_S);
    step_new = s_rnd[32:0];
    o_wide   = cfg.smooth_en ? (34'(held) + 34'(step_new)) : 34'(cmd_q);

    thr_w   = $signed({19'd0, cfg.thr});
    one_w   = 34'(ONE_Q14);
    in_band = (o_wide < thr_w) && (o_wide > -thr_w);
    // dead band snaps only when the command is exactly zero
    o_dz    = (in_band && (cmd_q == '0)) ? '0 : o_wide;

    if (o_dz > one_w) begin
      o_clamped = ONE_Q14;
    end else if (o_dz < -one_w) begin
      o_clamped = -ONE_Q14;
    end else begin
      o_clamped = o_dz[VEL_W-1:0];
    end

    res.vel    = o_clamped;
    res.moving = (o_dz > thr_w) || (o_dz < -thr_w);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd;
      dt_q   <= step_time;
      err_q  <= err_new;
      prod_p <= $signed({1'b0, cfg.kp}) * err_new;
      prod_d <= $signed({1'b0, cfg.kw}) * diff_new;
    end
    if (ctrl.mul) begin
      p_full <= prod_p * dt_s;
      d_q    <= d_rnd[26:0];
    end
    if (ctrl.acc) begin
      r_q <= r_sat;
    end
    if (ctrl.step) begin
      m_q <= r_q * dt_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      rate     <= '0;
      prev_err <= '0;
    end else begin
      if (ctrl.acc && cfg.smooth_en) begin
        rate     <= r_sat;
        prev_err <= err_q;
      end
      if (ctrl.fin) begin
        held <= o_clamped;
      end
    end
  end

endmodule

>>> sv/vcs_merge.sv
// merges lane results: ors the moving flags and holds the result request
// depends on vcs_pkg and vcs_channels
`timescale 1ns / 1ps

module vcs_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  vcs_pkg::vcs_lane_res_t lane_res [vcs_pkg::AXIS_COUNT],
  input  logic                   fin,
  output logic                   slot_free,
  vcs_res_if.source              res_ch
);
  import vcs_pkg::*;

  logic any_moving;

  always_comb begin
    any_moving = 1'b0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      any_moving = any_moving | lane_res[i].moving;
    end
  end

  assign slot_free = !res_ch.valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (fin) begin
      res_ch.valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res_ch.out_fwd   <= lane_res[AX_FWD].vel;
      res_ch.out_side  <= lane_res[AX_SIDE].vel;
      res_ch.out_yaw   <= lane_res[AX_YAW].vel;
      res_ch.is_moving <= any_moving;
    end
  end

endmodule
